// File: rtl/core/cspan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_pkg: shared types and constants of the filled circle span generator
// Widths, the circle record that travels through the queue, and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package cspan_pkg;

  localparam int MAX_RADIUS = 32;
  localparam int COORD_W    = 15;
  localparam int SPAN_W     = 16;
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int ROOT_W     = RAD_W;
  localparam int STEP_W     = $clog2(ROOT_W);
  localparam int VAL_W      = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [RAD_W-1:0]   rad;
  } circle_t;

  // One queue request: a circle with a nonzero radius.
  typedef struct packed {
    logic    valid;
    circle_t circ;
  } circle_req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_SPAN_LO,
    B_SPAN_HI
  } back_state_t;

endpackage

// File: rtl/core/cspan_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_in_if: circle request channel
// Valid/ready channel that carries one circle: centre and radius.
// ----------------------------------------------------------------------------
interface cspan_in_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] center_x;
  logic signed [14:0] center_y;
  logic        [5:0]  radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink (input valid, input center_x, input center_y, input radius,
                output ready);
endinterface

// File: rtl/core/cspan_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_out_if: span channel
// Valid/ready channel that carries one horizontal span.
// ----------------------------------------------------------------------------
interface cspan_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] span_row;
  logic signed [15:0] span_left;
  logic signed [15:0] span_right;
  logic               last_span;

  modport source (output valid, output span_row, output span_left, output span_right,
                  output last_span, input ready);
  modport sink (input valid, input span_row, input span_left, input span_right,
                input last_span, output ready);
endinterface

// File: rtl/core/cspan_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_front: request intake
// Accepts circle requests, clamps the radius and drops circles of radius
// zero; the rest go to the queue.
// ----------------------------------------------------------------------------
module cspan_front
  import cspan_pkg::*;
(
  cspan_in_if.sink    in_ch,
  input  logic        full,
  output circle_req_t push
);

  logic [RAD_W-1:0] rad_sat;

  always_comb begin
    if (in_ch.radius > 6'(MAX_RADIUS)) begin
      rad_sat = RAD_W'(MAX_RADIUS);
    end else begin
      rad_sat = RAD_W'(in_ch.radius);
    end
  end

  // A zero-radius request is taken and produces nothing.
  assign in_ch.ready    = !full;
  assign push.valid     = in_ch.valid && !full && (rad_sat != '0);
  assign push.circ.cx   = in_ch.center_x;
  assign push.circ.cy   = in_ch.center_y;
  assign push.circ.rad  = rad_sat;

endmodule

// File: rtl/core/cspan_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_queue: circle queue
// Short first-in first-out buffer that decouples intake from span
// generation.
// ----------------------------------------------------------------------------
module cspan_queue
  import cspan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  circle_req_t push,
  input  logic        pop,
  output logic        full,
  output circle_req_t head
);

  circle_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.circ  = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.circ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push.valid)
    else $error("push request while queue full");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

// File: rtl/core/cspan_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspan_back: span sequencer
// Walks the row offsets of one circle, takes the half width with a
// bit-serial integer square root and emits two spans per row offset.
// ----------------------------------------------------------------------------
module cspan_back
  import cspan_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  circle_req_t   head,
  output logic          pop,
  cspan_out_if.source   out_ch
);

  back_state_t        state;
  back_state_t        state_next;
  circle_t            circ;
  logic [RAD_W-1:0]   k;
  logic [VAL_W-1:0]   v;
  logic [ROOT_W-1:0]  root;
  logic [STEP_W-1:0]  bit_idx;
  logic               ov;
  logic               can_load;
  logic               load_lo;
  logic               load_hi;
  logic               last_row;

  logic [ROOT_W-1:0]    trial;
  logic [2*ROOT_W-1:0]  trial_sq;
  logic [RAD_W-1:0]     k_inc;
  logic [RAD_W:0]       diff_inc;
  logic [2*RAD_W:0]     v_inc;
  logic [RAD_W:0]       v_first;
  logic [SPAN_W-1:0]    cx16;
  logic [SPAN_W-1:0]    cy16;
  logic [SPAN_W-1:0]    r16;
  logic [SPAN_W-1:0]    k16;
  logic [SPAN_W-1:0]    h16;

  assign can_load = !ov || out_ch.ready;
  assign last_row = (k == circ.rad);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_lo    = 1'b0;
    load_hi    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = B_ROOT;
        end
      end
      B_ROOT: begin
        if (bit_idx == '0) begin
          state_next = B_SPAN_LO;
        end
      end
      B_SPAN_LO: begin
        if (can_load) begin
          load_lo    = 1'b1;
          state_next = B_SPAN_HI;
        end
      end
      B_SPAN_HI: begin
        if (can_load) begin
          load_hi    = 1'b1;
          state_next = last_row ? B_IDLE : B_ROOT;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // One root bit per cycle: keep the trial bit if its square stays within v.
  assign trial    = root | (ROOT_W'(1) << bit_idx);
  assign trial_sq = trial * trial;

  // Radicand for the next row offset, ready when the root starts again.
  assign k_inc    = k + 1'b1;
  assign diff_inc = {circ.rad, 1'b0} - {1'b0, k_inc};
  assign v_inc    = (2*RAD_W+1)'(k_inc) * (2*RAD_W+1)'(diff_inc);
  assign v_first  = {head.circ.rad, 1'b0} - (RAD_W+1)'(1);

  always_ff @(posedge clk) begin
    if (pop) begin
      circ    <= head.circ;
      k       <= RAD_W'(1);
      v       <= VAL_W'(v_first);
      root    <= '0;
      bit_idx <= STEP_W'(ROOT_W - 1);
    end else if (state == B_ROOT) begin
      if ({{(VAL_W > 2*ROOT_W ? VAL_W - 2*ROOT_W : 0){1'b0}}, trial_sq} <=
          {{(2*ROOT_W > VAL_W ? 2*ROOT_W - VAL_W : 0){1'b0}}, v}) begin
        root <= trial;
      end
      bit_idx <= bit_idx - 1'b1;
    end else if (load_hi && !last_row) begin
      k       <= k_inc;
      v       <= VAL_W'(v_inc);
      root    <= '0;
      bit_idx <= STEP_W'(ROOT_W - 1);
    end
  end

  assign cx16 = {{(SPAN_W-COORD_W){circ.cx[COORD_W-1]}}, circ.cx};
  assign cy16 = {{(SPAN_W-COORD_W){circ.cy[COORD_W-1]}}, circ.cy};
  assign r16  = SPAN_W'(circ.rad);
  assign k16  = SPAN_W'(k);
  assign h16  = SPAN_W'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_lo || load_hi) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_lo || load_hi) begin
      out_ch.span_row   <= load_lo ? (cy16 + r16 - k16) : (cy16 - r16 + k16);
      out_ch.span_left  <= cx16 - h16;
      out_ch.span_right <= cx16 + h16;
      out_ch.last_span  <= load_hi && last_row;
    end
  end

  assign out_ch.valid = ov;

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> (k != '0) && (k <= circ.rad))
    else $error("row offset outside one to radius");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (load_hi && last_row) |=> (state == B_IDLE) && out_ch.last_span)
    else $error("final span did not end the circle");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROOT && bit_idx == '0) |=> state == B_SPAN_LO)
    else $error("root did not finish after its last bit");

endmodule

// File: rtl/core/filled_circle_span_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator_top: filled circle span generator
// Turns each circle request into the horizontal spans that fill it.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries                                   Handshake
//  in_ch    in   center_x, center_y, radius                valid/ready
//  out_ch   out  span_row, span_left, span_right, last_span valid/ready
//
// In the span sequencer a circle is first taken from the queue; then each row
// offset takes six square-root steps and two span states, low then high.
// Reset is synchronous and clears the queue and sequencer. A two-entry queue
// takes requests until it is full while spans stall at the output, and the
// output register holds a span until it is taken.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_top
  import cspan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cspan_in_if.sink    in_ch,
  cspan_out_if.source out_ch
);

  circle_req_t push;
  circle_req_t head;
  logic        full;
  logic        pop;

  cspan_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push)
  );

  cspan_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  cspan_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the filled circle span generator
// Sends circle requests through the input channel, predicts the spans that
// fill each accepted circle and checks every span taken from the output
// channel against them in order. A table of directed circles comes first,
// then a long run of random circles, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import cspan_pkg::*;

  localparam int N_DIRECTED  = 19;
  localparam int N_RANDOM    = 200;
  localparam int MAX_IDLE    = 14;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic signed [SPAN_W-1:0] span_row;
    logic signed [SPAN_W-1:0] span_left;
    logic signed [SPAN_W-1:0] span_right;
    logic                     last_span;
  } span_t;

  // One row of the directed table. Where typed is set, the spans are taken
  // from exp_row/exp_left/exp_right: a radius of one gives that span twice,
  // a radius of zero gives nothing.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
    logic                      typed;
    logic signed [SPAN_W-1:0]  exp_row;
    logic signed [SPAN_W-1:0]  exp_left;
    logic signed [SPAN_W-1:0]  exp_right;
  } circle_row_t;

  localparam circle_row_t DIRECTED [N_DIRECTED] = '{
    '{0,      0,      0,  1, 0,      0,      0},
    '{0,      0,      1,  1, 0,      -1,     1},
    '{16383,  16383,  1,  1, 16383,  16382,  16384},
    '{-16384, -16384, 1,  1, -16384, -16385, -16383},
    '{16383,  -16384, 0,  1, 0,      0,      0},
    '{-1,     -1,     1,  1, -1,     -2,     0},
    '{0,      0,      2,  0, 0,      0,      0},
    '{100,    -200,   3,  0, 0,      0,      0},
    '{16383,  16383,  32, 0, 0,      0,      0},
    '{-16384, -16384, 32, 0, 0,      0,      0},
    '{16383,  -16384, 32, 0, 0,      0,      0},
    '{0,      0,      33, 0, 0,      0,      0},
    '{-16384, 16383,  63, 0, 0,      0,      0},
    '{5,      5,      31, 0, 0,      0,      0},
    '{-7,     9,      16, 0, 0,      0,      0},
    '{12345,  -12345, 5,  0, 0,      0,      0},
    '{1,      -1,     4,  0, 0,      0,      0},
    '{10922,  -10923, 42, 0, 0,      0,      0},
    '{-10923, 10922,  21, 0, 0,      0,      0}
  };

  logic clk = 1'b0;
  logic rst;

  cspan_in_if  in_ch ();
  cspan_out_if out_ch ();

  filled_circle_span_generator_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  span_t       expected_spans [$];
  circle_row_t circles_in_flight [$];
  int          err_count;
  int          cycle_count;
  int          circles_taken;
  int          spans_checked;
  int          saturated_circles;
  bit          quiet_phase;

  // Pushes every span that a circle of the given centre and radius fills.
  function automatic void predict_circle_spans(input logic signed [COORD_W-1:0] cx,
                                               input logic signed [COORD_W-1:0] cy,
                                               input logic [RAD_W-1:0] rad_in);
    int    r;
    int    k;
    int    h;
    int    area;
    span_t s;
    r = (rad_in > MAX_RADIUS) ? MAX_RADIUS : int'(rad_in);
    for (k = 1; k <= r; k++) begin
      area = 2 * r * k - k * k;
      h = 0;
      while ((h + 1) * (h + 1) <= area) h++;
      s.span_left  = SPAN_W'(int'(cx) - h);
      s.span_right = SPAN_W'(int'(cx) + h);
      s.span_row   = SPAN_W'(int'(cy) + r - k);
      s.last_span  = 1'b0;
      expected_spans.push_back(s);
      s.span_row   = SPAN_W'(int'(cy) - r + k);
      s.last_span  = (k == r);
      expected_spans.push_back(s);
    end
  endfunction

  task automatic send_circle(input circle_row_t c);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    circles_in_flight.push_back(c);
    in_ch.valid    <= 1'b1;
    in_ch.center_x <= c.cx;
    in_ch.center_y <= c.cy;
    in_ch.radius   <= c.rad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    circle_row_t c;
    int          sel;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius   = '0;
    quiet_phase    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_circle(DIRECTED[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_phase = ((i / 25) % 4 == 3);
      c = '0;
      c.cx = COORD_W'($urandom());
      c.cy = COORD_W'($urandom());
      // Mostly small circles keep the run short; a few saturate the radius.
      sel = $urandom_range(0, 99);
      if (sel < 60) c.rad = RAD_W'($urandom_range(0, 8));
      else if (sel < 85) c.rad = RAD_W'($urandom_range(9, MAX_RADIUS));
      else c.rad = RAD_W'($urandom_range(MAX_RADIUS + 1, 63));
      send_circle(c);
    end
    in_ch.valid <= 1'b0;
    quiet_phase = 1'b0;

    // Let the monitor record the last request before looking at the queues.
    @(posedge clk);
    while (expected_spans.size() != 0 || circles_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (circles_in_flight.size() != 0) begin
      $error("%0d circle requests were never accounted for", circles_in_flight.size());
      err_count++;
    end

    $display("Covered %0d circles (%0d with a saturated radius), %0d spans checked.",
             circles_taken, saturated_circles, spans_checked);
    $display("Mismatches and protocol errors: %0d", err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Span receiver: stalls a random number of cycles before each span.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted span.
  always @(posedge clk) begin : monitor
    circle_row_t item;
    span_t       want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        circles_taken++;
        if (in_ch.radius > MAX_RADIUS) saturated_circles++;
        if (circles_in_flight.size() == 0) begin
          $error("circle request accepted with no record of it being sent");
          err_count++;
        end else begin
          item = circles_in_flight.pop_front();
          if (item.typed) begin
            if (item.rad == 1) begin
              want = '{item.exp_row, item.exp_left, item.exp_right, 1'b0};
              expected_spans.push_back(want);
              want.last_span = 1'b1;
              expected_spans.push_back(want);
            end
          end else begin
            predict_circle_spans(in_ch.center_x, in_ch.center_y, in_ch.radius);
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        spans_checked++;
        if (expected_spans.size() == 0) begin
          $error("unexpected span: row %0d, left %0d, right %0d, last %0b",
                 out_ch.span_row, out_ch.span_left, out_ch.span_right, out_ch.last_span);
          err_count++;
        end else begin
          want = expected_spans.pop_front();
          if (out_ch.span_row !== want.span_row) begin
            $error("span_row: expected %0d, got %0d", want.span_row, out_ch.span_row);
            err_count++;
          end
          if (out_ch.span_left !== want.span_left) begin
            $error("span_left: expected %0d, got %0d", want.span_left, out_ch.span_left);
            err_count++;
          end
          if (out_ch.span_right !== want.span_right) begin
            $error("span_right: expected %0d, got %0d", want.span_right, out_ch.span_right);
            err_count++;
          end
          if (out_ch.last_span !== want.last_span) begin
            $error("last_span: expected %0b, got %0b", want.last_span, out_ch.last_span);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d spans outstanding.",
               cycle_count, expected_spans.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/core/cspan_pkg.sv
rtl/core/cspan_in_if.sv
rtl/core/cspan_out_if.sv
rtl/core/cspan_front.sv
rtl/core/cspan_queue.sv
rtl/core/cspan_back.sv
rtl/core/filled_circle_span_generator_top.sv
tb/tb_top.sv
